>>> rtl/q4_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and rounding helpers for the quad4 gradient block.
// Depends on nothing; every other file imports it.
package q4_pkg;

   localparam int FRAC_BITS = 16;
   localparam int XI_W      = 18;
   localparam int NAT_W     = XI_W + 1;
   localparam int CRD_W     = 32;
   localparam int DIFF_W    = CRD_W + 1;
   localparam int PROD_W    = NAT_W + DIFF_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int SHP_W     = 2 * NAT_W;
   localparam int J_W       = 32;
   localparam int DET_W     = 2 * J_W;
   localparam int DMAG_W    = DET_W - 1;
   localparam int NPROD_W   = NAT_W + J_W;
   localparam int NUM_W     = NPROD_W + 1;
   localparam int JRND      = FRAC_BITS + 2;
   localparam int DIV_SHIFT = FRAC_BITS - 1;
   localparam int QBITS     = J_W + 2;
   localparam int PRE       = QBITS - DIV_SHIFT;
   localparam int REM_W     = DMAG_W + 1;
   localparam int WIDE_W    = 64;

   localparam logic signed [NAT_W-1:0] ONE_NAT = NAT_W'(1) << FRAC_BITS;
   localparam logic signed [J_W-1:0] S32_MAX = {1'b0, {(J_W-1){1'b1}}};
   localparam logic signed [J_W-1:0] S32_MIN = {1'b1, {(J_W-1){1'b0}}};
   localparam logic [J_W:0] QUOT_LIM  = {1'b1, {J_W{1'b0}}};
   localparam logic [J_W:0] QUOT_HALF = {2'b01, {(J_W-1){1'b0}}};

   localparam logic [1:0] NODE_FIRST = 2'd0;
   localparam logic [1:0] NODE_SECOND = 2'd1;
   localparam logic [1:0] NODE_THIRD = 2'd2;
   localparam logic [1:0] NODE_LAST = 2'd3;

   typedef struct packed {
      logic signed [XI_W-1:0]  xi;
      logic signed [XI_W-1:0]  eta;
      logic [3:0][CRD_W-1:0]   px;
      logic [3:0][CRD_W-1:0]   py;
   } item_type;

   typedef struct packed {
      logic                    valid;
      logic [1:0]              node;
      logic signed [J_W-1:0]   shape;
      logic                    sing;
      logic                    negx;
      logic                    negy;
      logic [NUM_W-1:0]        nx;
      logic [NUM_W-1:0]        ny;
      logic [DMAG_W-1:0]       d;
   } div_req_type;

   typedef struct packed {
      logic                    valid;
      logic [1:0]              node;
      logic signed [J_W-1:0]   shape;
      logic                    sing;
      logic                    negx;
      logic                    negy;
      logic                    satx;
      logic                    saty;
      logic [QBITS-1:0]        qx;
      logic [QBITS-1:0]        qy;
   } div_rsp_type;

   // Round v / 2^s to nearest with ties away from zero, then saturate to 32 bits.
   function automatic logic signed [J_W-1:0] rnd_sat(input logic signed [WIDE_W-1:0] v,
                                                     input int s);
      logic [WIDE_W-1:0]        m;
      logic [WIDE_W-1:0]        r;
      logic signed [WIDE_W-1:0] t;
      m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
      r = (m + (WIDE_W'(1) << (s - 1))) >> s;
      t = v[WIDE_W-1] ? -$signed(r) : $signed(r);
      if (t > WIDE_W'(S32_MAX)) begin
         return S32_MAX;
      end else if (t < WIDE_W'(S32_MIN)) begin
         return S32_MIN;
      end
      return J_W'(t);
   endfunction

   // Turn a truncated quotient with one extra fraction bit into the rounded,
   // signed and saturated 32-bit gradient.
   function automatic logic signed [J_W-1:0] quot_fix(input logic [QBITS-1:0] q,
                                                      input logic sat, input logic neg);
      logic [QBITS:0] r;
      logic [J_W:0]   m;
      r = ({1'b0, q} + (QBITS+1)'(1)) >> 1;
      if (sat || r > (QBITS+1)'(QUOT_LIM)) begin
         m = QUOT_LIM;
      end else begin
         m = (J_W+1)'(r);
      end
      if (neg) begin
         return (m > QUOT_HALF) ? S32_MIN : J_W'(-m);
      end
      return (m > (J_W+1)'(S32_MAX)) ? S32_MAX : J_W'(m);
   endfunction

endpackage

>>> rtl/q4_front.sv
`timescale 1ns / 1ps
// Front pipeline: shape value, Jacobian, determinant and gradient numerators per node.
// Depends on q4_pkg.
module q4_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [1:0]             in_node,
   input  q4_pkg::item_type       in_item,
   output q4_pkg::div_req_type    out_req
);
   import q4_pkg::*;

   typedef struct packed {
      logic                     valid;
      logic [1:0]               node;
      logic signed [NAT_W-1:0]  a, b, c, e, f1, f2, dxi, deta;
      logic signed [DIFF_W-1:0] dx10, dx23, dx30, dx21, dy10, dy23, dy30, dy21;
   } s1_type;

   typedef struct packed {
      logic                     valid;
      logic [1:0]               node;
      logic signed [NAT_W-1:0]  dxi, deta;
      logic signed [PROD_W-1:0] mx0a, mx0b, mx1a, mx1b, my0a, my0b, my1a, my1b;
      logic signed [SHP_W-1:0]  shp;
   } s2_type;

   typedef struct packed {
      logic                     valid;
      logic [1:0]               node;
      logic signed [NAT_W-1:0]  dxi, deta;
      logic signed [ACC_W-1:0]  a00, a01, a10, a11;
      logic signed [J_W-1:0]    shape;
   } s3_type;

   typedef struct packed {
      logic                     valid;
      logic [1:0]               node;
      logic signed [NAT_W-1:0]  dxi, deta;
      logic signed [J_W-1:0]    j00, j01, j10, j11;
      logic signed [J_W-1:0]    shape;
   } s4_type;

   typedef struct packed {
      logic                      valid;
      logic [1:0]                node;
      logic signed [DET_W-1:0]   pd1, pd2;
      logic signed [NPROD_W-1:0] px1, px2, py1, py2;
      logic signed [J_W-1:0]     shape;
   } s5_type;

   typedef struct packed {
      logic                     valid;
      logic [1:0]               node;
      logic signed [DET_W-1:0]  det;
      logic signed [NUM_W-1:0]  numx, numy;
      logic signed [J_W-1:0]    shape;
   } s6_type;

   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   s5_type      s5_ff, s5_in;
   s6_type      s6_ff, s6_in;
   div_req_type s7_ff, s7_in;

   function automatic logic signed [DIFF_W-1:0] cdiff(input logic [CRD_W-1:0] p,
                                                      input logic [CRD_W-1:0] q);
      return DIFF_W'($signed(p)) - DIFF_W'($signed(q));
   endfunction

   function automatic logic signed [J_W-1:0] jclamp(input logic signed [ACC_W-1:0] v);
      logic signed [J_W-1:0] j;
      j = rnd_sat(WIDE_W'(v), JRND);
      return (j == S32_MIN) ? S32_MIN + J_W'(1) : j;
   endfunction

   // Stage 1: natural factors, per-node derivative selection, coordinate differences.
   always_comb begin
      logic signed [NAT_W-1:0] xi_n, eta_n;
      xi_n  = NAT_W'(in_item.xi);
      eta_n = NAT_W'(in_item.eta);
      s1_in.valid = in_valid;
      s1_in.node  = in_node;
      s1_in.a = ONE_NAT - xi_n;
      s1_in.b = ONE_NAT + xi_n;
      s1_in.c = ONE_NAT - eta_n;
      s1_in.e = ONE_NAT + eta_n;
      unique case (in_node)
         NODE_FIRST: begin
            s1_in.f1 = s1_in.a; s1_in.f2 = s1_in.c;
            s1_in.dxi = -s1_in.c; s1_in.deta = -s1_in.a;
         end
         NODE_SECOND: begin
            s1_in.f1 = s1_in.b; s1_in.f2 = s1_in.c;
            s1_in.dxi = s1_in.c; s1_in.deta = -s1_in.b;
         end
         NODE_THIRD: begin
            s1_in.f1 = s1_in.b; s1_in.f2 = s1_in.e;
            s1_in.dxi = s1_in.e; s1_in.deta = s1_in.b;
         end
         default: begin
            s1_in.f1 = s1_in.a; s1_in.f2 = s1_in.e;
            s1_in.dxi = -s1_in.e; s1_in.deta = s1_in.a;
         end
      endcase
      s1_in.dx10 = cdiff(in_item.px[1], in_item.px[0]);
      s1_in.dx23 = cdiff(in_item.px[2], in_item.px[3]);
      s1_in.dx30 = cdiff(in_item.px[3], in_item.px[0]);
      s1_in.dx21 = cdiff(in_item.px[2], in_item.px[1]);
      s1_in.dy10 = cdiff(in_item.py[1], in_item.py[0]);
      s1_in.dy23 = cdiff(in_item.py[2], in_item.py[3]);
      s1_in.dy30 = cdiff(in_item.py[3], in_item.py[0]);
      s1_in.dy21 = cdiff(in_item.py[2], in_item.py[1]);
   end

   // Stage 2: the Jacobian sums factor into two products per entry.
   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.node  = s1_ff.node;
      s2_in.dxi   = s1_ff.dxi;
      s2_in.deta  = s1_ff.deta;
      s2_in.mx0a  = s1_ff.c * s1_ff.dx10;
      s2_in.mx0b  = s1_ff.e * s1_ff.dx23;
      s2_in.mx1a  = s1_ff.a * s1_ff.dx30;
      s2_in.mx1b  = s1_ff.b * s1_ff.dx21;
      s2_in.my0a  = s1_ff.c * s1_ff.dy10;
      s2_in.my0b  = s1_ff.e * s1_ff.dy23;
      s2_in.my1a  = s1_ff.a * s1_ff.dy30;
      s2_in.my1b  = s1_ff.b * s1_ff.dy21;
      s2_in.shp   = s1_ff.f1 * s1_ff.f2;
   end

   // Stage 3: Jacobian sums and the rounded shape value.
   always_comb begin
      s3_in.valid = s2_ff.valid;
      s3_in.node  = s2_ff.node;
      s3_in.dxi   = s2_ff.dxi;
      s3_in.deta  = s2_ff.deta;
      s3_in.a00   = ACC_W'(s2_ff.mx0a) + ACC_W'(s2_ff.mx0b);
      s3_in.a01   = ACC_W'(s2_ff.mx1a) + ACC_W'(s2_ff.mx1b);
      s3_in.a10   = ACC_W'(s2_ff.my0a) + ACC_W'(s2_ff.my0b);
      s3_in.a11   = ACC_W'(s2_ff.my1a) + ACC_W'(s2_ff.my1b);
      s3_in.shape = rnd_sat(WIDE_W'(s2_ff.shp), JRND);
   end

   // Stage 4: quantized Jacobian entries, kept off the most negative code.
   always_comb begin
      s4_in.valid = s3_ff.valid;
      s4_in.node  = s3_ff.node;
      s4_in.dxi   = s3_ff.dxi;
      s4_in.deta  = s3_ff.deta;
      s4_in.shape = s3_ff.shape;
      s4_in.j00   = jclamp(s3_ff.a00);
      s4_in.j01   = jclamp(s3_ff.a01);
      s4_in.j10   = jclamp(s3_ff.a10);
      s4_in.j11   = jclamp(s3_ff.a11);
   end

   // Stage 5: determinant and numerator products.
   always_comb begin
      s5_in.valid = s4_ff.valid;
      s5_in.node  = s4_ff.node;
      s5_in.shape = s4_ff.shape;
      s5_in.pd1   = s4_ff.j00 * s4_ff.j11;
      s5_in.pd2   = s4_ff.j01 * s4_ff.j10;
      s5_in.px1   = s4_ff.dxi * s4_ff.j11;
      s5_in.px2   = s4_ff.deta * s4_ff.j10;
      s5_in.py1   = s4_ff.deta * s4_ff.j00;
      s5_in.py2   = s4_ff.dxi * s4_ff.j01;
   end

   // Stage 6: differences.
   always_comb begin
      s6_in.valid = s5_ff.valid;
      s6_in.node  = s5_ff.node;
      s6_in.shape = s5_ff.shape;
      s6_in.det   = s5_ff.pd1 - s5_ff.pd2;
      s6_in.numx  = NUM_W'(s5_ff.px1) - NUM_W'(s5_ff.px2);
      s6_in.numy  = NUM_W'(s5_ff.py1) - NUM_W'(s5_ff.py2);
   end

   // Stage 7: magnitudes and signs for the unsigned divider.
   always_comb begin
      logic [DET_W-1:0] dm;
      dm = s6_ff.det[DET_W-1] ? DET_W'(-s6_ff.det) : DET_W'(s6_ff.det);
      s7_in.valid = s6_ff.valid;
      s7_in.node  = s6_ff.node;
      s7_in.shape = s6_ff.shape;
      s7_in.sing  = (s6_ff.det == '0);
      s7_in.negx  = s6_ff.numx[NUM_W-1] ^ s6_ff.det[DET_W-1];
      s7_in.negy  = s6_ff.numy[NUM_W-1] ^ s6_ff.det[DET_W-1];
      s7_in.nx    = s6_ff.numx[NUM_W-1] ? NUM_W'(-s6_ff.numx) : NUM_W'(s6_ff.numx);
      s7_in.ny    = s6_ff.numy[NUM_W-1] ? NUM_W'(-s6_ff.numy) : NUM_W'(s6_ff.numy);
      s7_in.d     = dm[DMAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
         s7_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   assign out_req = s7_ff;

endmodule

>>> rtl/q4_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage for both gradient lanes.
// Depends on q4_pkg.
module q4_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  q4_pkg::div_req_type    in_req,
   output q4_pkg::div_rsp_type    out_rsp
);
   import q4_pkg::*;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QBITS-1:0] low;
      logic [QBITS-1:0] q;
   } lane_type;

   typedef struct packed {
      logic                  valid;
      logic [1:0]            node;
      logic signed [J_W-1:0] shape;
      logic                  sing;
      logic                  negx;
      logic                  negy;
      logic                  satx;
      logic                  saty;
      logic [DMAG_W-1:0]     d;
      lane_type              lx;
      lane_type              ly;
   } stage_type;

   stage_type stage_ff [QBITS+1];
   stage_type stage_in [QBITS+1];

   function automatic lane_type div_step(input lane_type l, input logic [DMAG_W-1:0] d);
      lane_type         r;
      logic [REM_W-1:0] rt;
      logic             ge;
      rt = {l.rem[REM_W-2:0], l.low[QBITS-1]};
      ge = (rt >= REM_W'(d));
      r.rem = ge ? rt - REM_W'(d) : rt;
      r.low = l.low << 1;
      r.q   = {l.q[QBITS-2:0], ge};
      return r;
   endfunction

   // The dividend is |num| * 2^DIV_SHIFT; its top bits form the starting
   // remainder, and the quotient overflows exactly when that is not below d.
   always_comb begin
      stage_in[0].valid  = in_req.valid;
      stage_in[0].node   = in_req.node;
      stage_in[0].shape  = in_req.shape;
      stage_in[0].sing   = in_req.sing;
      stage_in[0].negx   = in_req.negx;
      stage_in[0].negy   = in_req.negy;
      stage_in[0].d      = in_req.d;
      stage_in[0].satx   = REM_W'(in_req.nx >> PRE) >= REM_W'(in_req.d);
      stage_in[0].saty   = REM_W'(in_req.ny >> PRE) >= REM_W'(in_req.d);
      stage_in[0].lx.rem = REM_W'(in_req.nx >> PRE);
      stage_in[0].ly.rem = REM_W'(in_req.ny >> PRE);
      stage_in[0].lx.low = {in_req.nx[PRE-1:0], {DIV_SHIFT{1'b0}}};
      stage_in[0].ly.low = {in_req.ny[PRE-1:0], {DIV_SHIFT{1'b0}}};
      stage_in[0].lx.q   = '0;
      stage_in[0].ly.q   = '0;
   end

   for (genvar k = 1; k <= QBITS; k++) begin : g_step
      always_comb begin
         stage_in[k]    = stage_ff[k-1];
         stage_in[k].lx = div_step(stage_ff[k-1].lx, stage_ff[k-1].d);
         stage_in[k].ly = div_step(stage_ff[k-1].ly, stage_ff[k-1].d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QBITS; k++) begin
            stage_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k <= QBITS; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_rsp.valid = stage_ff[QBITS].valid;
   assign out_rsp.node  = stage_ff[QBITS].node;
   assign out_rsp.shape = stage_ff[QBITS].shape;
   assign out_rsp.sing  = stage_ff[QBITS].sing;
   assign out_rsp.negx  = stage_ff[QBITS].negx;
   assign out_rsp.negy  = stage_ff[QBITS].negy;
   assign out_rsp.satx  = stage_ff[QBITS].satx;
   assign out_rsp.saty  = stage_ff[QBITS].saty;
   assign out_rsp.qx    = stage_ff[QBITS].lx.q;
   assign out_rsp.qy    = stage_ff[QBITS].ly.q;

endmodule

>>> rtl/quad4_shape_function_gradients.sv
`timescale 1ns / 1ps
// Throughput: one result per cycle unless the output stalls. The input register issues
// an item's four node slots and takes the next item as the last one issues; everything behind it is fully pipelined.
// Reset clears the valid bits and the node counter; no other state needs clearing and the block is ready at once.
// Depends on q4_pkg, q4_front and q4_div.
module quad4_shape_function_gradients (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [q4_pkg::XI_W-1:0]  req_xi,
   input  logic signed [q4_pkg::XI_W-1:0]  req_eta,
   input  logic signed [q4_pkg::CRD_W-1:0] req_node1_x,
   input  logic signed [q4_pkg::CRD_W-1:0] req_node1_y,
   input  logic signed [q4_pkg::CRD_W-1:0] req_node2_x,
   input  logic signed [q4_pkg::CRD_W-1:0] req_node2_y,
   input  logic signed [q4_pkg::CRD_W-1:0] req_node3_x,
   input  logic signed [q4_pkg::CRD_W-1:0] req_node3_y,
   input  logic signed [q4_pkg::CRD_W-1:0] req_node4_x,
   input  logic signed [q4_pkg::CRD_W-1:0] req_node4_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_node_index,
   output logic signed [q4_pkg::J_W-1:0]   rsp_shape_value,
   output logic signed [q4_pkg::J_W-1:0]   rsp_dn_dx,
   output logic signed [q4_pkg::J_W-1:0]   rsp_dn_dy,
   output logic                            rsp_singular,
   output logic                            rsp_last
);
   import q4_pkg::*;

   // The whole pipeline moves as one: it advances whenever the output register
   // is empty or its item is being taken, so a stall holds every stage in place.
   logic adv;

   // Input register. An accepted item is held here while its four node slots
   // are issued, one per advancing cycle, into the front pipeline.
   item_type   item_ff;
   logic       item_valid_ff;
   logic [1:0] node_cnt_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_node_ff;
   logic signed [J_W-1:0] rsp_shape_ff;
   logic signed [J_W-1:0] rsp_dx_ff;
   logic signed [J_W-1:0] rsp_dy_ff;
   logic                  rsp_sing_ff;
   logic signed [J_W-1:0] dx_in;
   logic signed [J_W-1:0] dy_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && (!item_valid_ff || node_cnt_ff == NODE_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         node_cnt_ff   <= NODE_FIRST;
      end else if (adv) begin
         if (req_valid && req_ready) begin
            item_valid_ff <= 1'b1;
            node_cnt_ff   <= NODE_FIRST;
            item_ff.xi    <= req_xi;
            item_ff.eta   <= req_eta;
            item_ff.px    <= {req_node4_x, req_node3_x, req_node2_x, req_node1_x};
            item_ff.py    <= {req_node4_y, req_node3_y, req_node2_y, req_node1_y};
         end else if (item_valid_ff) begin
            if (node_cnt_ff == NODE_LAST) begin
               item_valid_ff <= 1'b0;
            end
            node_cnt_ff <= node_cnt_ff + 2'd1;
         end
      end
   end

   // Shape value, Jacobian, determinant and the two numerators, seven stages.
   q4_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (item_valid_ff),
      .in_node  (node_cnt_ff),
      .in_item  (item_ff),
      .out_req  (div_req)
   );

   // Both divisions by the determinant, one quotient bit per stage.
   q4_div u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_req  (div_req),
      .out_rsp (div_rsp)
   );

   // Final rounding and saturation of the quotients. A singular Jacobian forces
   // both derivatives to zero while the shape value still goes out.
   always_comb begin
      dx_in = div_rsp.sing ? '0 : quot_fix(div_rsp.qx, div_rsp.satx, div_rsp.negx);
      dy_in = div_rsp.sing ? '0 : quot_fix(div_rsp.qy, div_rsp.saty, div_rsp.negy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_rsp.valid;
         rsp_node_ff  <= div_rsp.node;
         rsp_shape_ff <= div_rsp.shape;
         rsp_sing_ff  <= div_rsp.sing;
         rsp_dx_ff    <= dx_in;
         rsp_dy_ff    <= dy_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = rsp_node_ff;
   assign rsp_shape_value = rsp_shape_ff;
   assign rsp_dn_dx       = rsp_dx_ff;
   assign rsp_dn_dy       = rsp_dy_ff;
   assign rsp_singular    = rsp_sing_ff;
   assign rsp_last        = (rsp_node_ff == NODE_LAST);

   // A singular result never carries a nonzero derivative.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_dn_dx == '0 && rsp_dn_dy == '0)
      else $error("singular result with nonzero derivative");

   // Results of one item come out in node order with no gaps inside the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         !rsp_valid || rsp_node_index == $past(rsp_node_index) + 2'd1)
      else $error("node results out of order");

   // A stall freezes the node sequencer.
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !adv |=> item_valid_ff && $stable(node_cnt_ff))
      else $error("node sequencer moved during a stall");

   // A new item is taken only when the previous one has issued all its nodes.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && item_valid_ff |-> node_cnt_ff == NODE_LAST)
      else $error("item accepted while nodes were still pending");

endmodule

>>> sim/quad4_shape_function_gradients_test.sv
`timescale 1ns / 1ps
// Self-checking bench for quad4_shape_function_gradients: directed and random quads,
// with a predictor of the shape values and physical gradients. Depends on q4_pkg and the RTL.
module quad4_shape_function_gradients_test;
   import q4_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;

   // One evaluation point with its quad, plus the idling profile it is sent under.
   typedef struct {
      logic signed [XI_W-1:0]  xi;
      logic signed [XI_W-1:0]  eta;
      logic signed [CRD_W-1:0] px[4];
      logic signed [CRD_W-1:0] py[4];
      int                      send_idle;
      int                      recv_stall;
      bit                      wait_empty;
   } point_item_type;

   typedef struct {
      logic [1:0]            node;
      logic signed [J_W-1:0] shape;
      logic signed [J_W-1:0] dx;
      logic signed [J_W-1:0] dy;
      logic                  sing;
      logic                  last;
   } node_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [XI_W-1:0]  req_xi = '0;
   logic signed [XI_W-1:0]  req_eta = '0;
   logic signed [CRD_W-1:0] req_node1_x = '0, req_node1_y = '0;
   logic signed [CRD_W-1:0] req_node2_x = '0, req_node2_y = '0;
   logic signed [CRD_W-1:0] req_node3_x = '0, req_node3_y = '0;
   logic signed [CRD_W-1:0] req_node4_x = '0, req_node4_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_node_index;
   logic signed [J_W-1:0] rsp_shape_value, rsp_dn_dx, rsp_dn_dy;
   logic rsp_singular, rsp_last;

   point_item_type  point_queue[$];
   node_result_type node_results_due[$];
   int  error_count = 0;
   int  points_sent = 0;
   int  results_seen = 0;
   int  singular_seen = 0;
   int  idle_cycles = 0;
   int  stall_pct = 0;
   bit  points_done = 1'b0;
   bit  req_taken = 1'b0;

   always #2 clock = ~clock;

   quad4_shape_function_gradients u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_xi(req_xi), .req_eta(req_eta),
      .req_node1_x(req_node1_x), .req_node1_y(req_node1_y),
      .req_node2_x(req_node2_x), .req_node2_y(req_node2_y),
      .req_node3_x(req_node3_x), .req_node3_y(req_node3_y),
      .req_node4_x(req_node4_x), .req_node4_y(req_node4_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_node_index(rsp_node_index), .rsp_shape_value(rsp_shape_value),
      .rsp_dn_dx(rsp_dn_dx), .rsp_dn_dy(rsp_dn_dy),
      .rsp_singular(rsp_singular), .rsp_last(rsp_last)
   );

   // Divide by 2^s, rounding to nearest with ties away from zero.
   function automatic longint round_shift(longint v, int s);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : v;
      m = (m + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Rounded quotient num * 2^s / den, saturated to 32 bits. The quotient is
   // developed one fraction bit at a time so that nothing overflows 64 bits.
   function automatic longint gradient_quotient(longint num, longint den, int s);
      bit neg;
      longint unsigned n, d, q, r, lim;
      bit sat;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? longint'(-num) : num;
      d = (den < 0) ? longint'(-den) : den;
      lim = 64'd1 << 32;
      q = n / d;
      r = n % d;
      sat = q > lim;
      for (int k = 0; k < s && !sat; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
         if (q > lim) sat = 1'b1;
      end
      if (!sat && (r << 1) >= d) q = q + 1;
      if (sat || q > lim) q = lim;
      if (neg) return (q > (64'd1 << 31)) ? -64'sd2147483648 : -longint'(q);
      return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
   endfunction

   // Expected four node results of one evaluation point, pushed in node order.
   task automatic predict_gradients(input point_item_type p);
      longint one, xi, eta, det, gx, gy;
      longint x[4], y[4], dxi[4], deta[4], shp[4];
      longint a00, a01, a10, a11, j00, j01, j10, j11;
      node_result_type res;
      one = longint'(1) << FRAC_BITS;
      xi = p.xi;
      eta = p.eta;
      for (int i = 0; i < 4; i++) begin
         x[i] = p.px[i];
         y[i] = p.py[i];
      end
      shp[0] = (one - xi) * (one - eta);
      shp[1] = (one + xi) * (one - eta);
      shp[2] = (one + xi) * (one + eta);
      shp[3] = (one - xi) * (one + eta);
      dxi[0] = eta - one;     deta[0] = xi - one;
      dxi[1] = one - eta;     deta[1] = -(one + xi);
      dxi[2] = one + eta;     deta[2] = one + xi;
      dxi[3] = -(one + eta);  deta[3] = one - xi;
      a00 = 0; a01 = 0; a10 = 0; a11 = 0;
      for (int i = 0; i < 4; i++) begin
         a00 += dxi[i] * x[i];
         a01 += deta[i] * x[i];
         a10 += dxi[i] * y[i];
         a11 += deta[i] * y[i];
      end
      // Jacobian entries are kept symmetric: the most negative code is clipped.
      j00 = clamp32(round_shift(a00, FRAC_BITS + 2));
      j01 = clamp32(round_shift(a01, FRAC_BITS + 2));
      j10 = clamp32(round_shift(a10, FRAC_BITS + 2));
      j11 = clamp32(round_shift(a11, FRAC_BITS + 2));
      if (j00 < -64'sd2147483647) j00 = -64'sd2147483647;
      if (j01 < -64'sd2147483647) j01 = -64'sd2147483647;
      if (j10 < -64'sd2147483647) j10 = -64'sd2147483647;
      if (j11 < -64'sd2147483647) j11 = -64'sd2147483647;
      det = j00 * j11 - j01 * j10;
      for (int i = 0; i < 4; i++) begin
         gx = 0;
         gy = 0;
         if (det != 0) begin
            gx = gradient_quotient(dxi[i] * j11 - deta[i] * j10, det, FRAC_BITS - 2);
            gy = gradient_quotient(deta[i] * j00 - dxi[i] * j01, det, FRAC_BITS - 2);
         end
         res.node  = 2'(i);
         res.shape = J_W'(clamp32(round_shift(shp[i], FRAC_BITS + 2)));
         res.dx    = J_W'(gx);
         res.dy    = J_W'(gy);
         res.sing  = (det == 0);
         res.last  = (2'(i) == NODE_LAST);
         node_results_due.push_back(res);
      end
   endtask

   // Input side: holds the payload until it is taken, otherwise offers the next
   // queued point unless this cycle is chosen to idle. A point marked to wait
   // is held back until the block has returned everything it owes.
   always @(negedge clock) begin
      point_item_type p;
      if (!reset && !(req_valid && !req_taken)) begin
         if (point_queue.size() > 0 &&
             !(point_queue[0].wait_empty && node_results_due.size() > 0) &&
             $urandom_range(99) >= point_queue[0].send_idle) begin
            p = point_queue.pop_front();
            req_xi <= p.xi;
            req_eta <= p.eta;
            req_node1_x <= p.px[0]; req_node1_y <= p.py[0];
            req_node2_x <= p.px[1]; req_node2_y <= p.py[1];
            req_node3_x <= p.px[2]; req_node3_y <= p.py[2];
            req_node4_x <= p.px[3]; req_node4_y <= p.py[3];
            stall_pct = p.recv_stall;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Output side and scoreboard: predictions are made when an item is taken,
   // and every result is matched against the oldest one outstanding.
   always @(posedge clock) begin
      point_item_type p;
      node_result_type want;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p.xi = req_xi;
            p.eta = req_eta;
            p.px[0] = req_node1_x; p.py[0] = req_node1_y;
            p.px[1] = req_node2_x; p.py[1] = req_node2_y;
            p.px[2] = req_node3_x; p.py[2] = req_node3_y;
            p.px[3] = req_node4_x; p.py[3] = req_node4_y;
            predict_gradients(p);
            points_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_singular) singular_seen++;
            if (node_results_due.size() == 0) begin
               $display("%0t: unexpected result node %0d shape %0d dx %0d dy %0d",
                        $time, rsp_node_index, rsp_shape_value, rsp_dn_dx, rsp_dn_dy);
               error_count++;
            end else begin
               want = node_results_due.pop_front();
               if (rsp_node_index !== want.node || rsp_shape_value !== want.shape ||
                   rsp_dn_dx !== want.dx || rsp_dn_dy !== want.dy ||
                   rsp_singular !== want.sing || rsp_last !== want.last) begin
                  $display("%0t: expected node %0d shape %0d dx %0d dy %0d sing %0b last %0b",
                           $time, want.node, want.shape, want.dx, want.dy, want.sing, want.last);
                  $display("%0t: actual   node %0d shape %0d dx %0d dy %0d sing %0b last %0b",
                           $time, rsp_node_index, rsp_shape_value, rsp_dn_dx, rsp_dn_dy,
                           rsp_singular, rsp_last);
                  error_count++;
               end
            end
         end
         // The watchdog restarts whenever either channel moves an item.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else if (!points_done || node_results_due.size() > 0) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no progress for %0d cycles, %0d results outstanding",
                        $time, WATCHDOG_LIMIT, node_results_due.size());
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   function automatic point_item_type make_point(int xi, int eta, int x0, int y0, int x1,
                                                 int y1, int x2, int y2, int x3, int y3);
      point_item_type p;
      p.xi = XI_W'(xi);
      p.eta = XI_W'(eta);
      p.px[0] = x0; p.py[0] = y0;
      p.px[1] = x1; p.py[1] = y1;
      p.px[2] = x2; p.py[2] = y2;
      p.px[3] = x3; p.py[3] = y3;
      p.send_idle = 0;
      p.recv_stall = 0;
      p.wait_empty = 1'b0;
      return p;
   endfunction

   function automatic int rand_nat();
      return int'($urandom_range(131072)) - 65536;
   endfunction

   // A random point on a sensible convex-ish quad, or pure noise coordinates.
   function automatic point_item_type random_point(int send_idle, int recv_stall);
      point_item_type p;
      int cx, cy, h, w;
      cx = $signed($urandom) >>> 4;
      cy = $signed($urandom) >>> 4;
      h = $urandom_range(1 << 26, 1 << 10);
      w = $urandom_range(1 << 26, 1 << 10);
      if ($urandom_range(99) < 80) begin
         p = make_point(rand_nat(), rand_nat(),
                        cx - w + $urandom_range(w / 4), cy - h + $urandom_range(h / 4),
                        cx + w - $urandom_range(w / 4), cy - h + $urandom_range(h / 4),
                        cx + w - $urandom_range(w / 4), cy + h - $urandom_range(h / 4),
                        cx - w + $urandom_range(w / 4), cy + h - $urandom_range(h / 4));
      end else begin
         p = make_point(rand_nat(), rand_nat(), $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
      end
      p.send_idle = send_idle;
      p.recv_stall = recv_stall;
      return p;
   endfunction

   initial begin
      int one;
      int mx, mn;
      point_item_type p;
      int send_pct[4];
      int recv_pct[4];
      one = 1 << FRAC_BITS;
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      send_pct = '{0, 76, 0, 30};
      recv_pct = '{0, 0, 76, 30};

      // Directed: unit square at its center and corners, natural coordinate extremes.
      point_queue.push_back(make_point(0, 0, -one, -one, one, -one, one, one, -one, one));
      point_queue.push_back(make_point(-one, -one, -one, -one, one, -one, one, one, -one, one));
      point_queue.push_back(make_point(one, one, -one, -one, one, -one, one, one, -one, one));
      point_queue.push_back(make_point(one, -one, 0, 0, one, 0, one, one, 0, one));
      point_queue.push_back(make_point(-one, one, 0, 0, 3 * one, 0, 2 * one, one, 0, 2 * one));
      // Zero determinant: every node on one spot, and all nodes on one line.
      point_queue.push_back(make_point(12345, -54321, 0, 0, 0, 0, 0, 0, 0, 0));
      point_queue.push_back(make_point(0, 0, 0, 0, one, one, 2 * one, 2 * one, 3 * one, 3 * one));
      // Tiny element: the gradients blow up and saturate.
      point_queue.push_back(make_point(0, 0, 0, 0, 1, 0, 1, 1, 0, 1));
      point_queue.push_back(make_point(one, 0, 0, 0, 1, 0, 1, 2, 0, 1));
      // Huge elements: Jacobian entries saturate, mixed signs and extremes.
      point_queue.push_back(make_point(0, 0, mn, mn, mx, mn, mx, mx, mn, mx));
      point_queue.push_back(make_point(-one, one, mx, mn, mn, mx, mx, mx, mn, mn));
      point_queue.push_back(make_point(one, one, mx, mx, mx, mx, mn, mn, mn, mn));
      point_queue.push_back(make_point(-one, -one, mn, mn, mn, mn, mn, mn, mn, mn));
      // Inverted (clockwise) element gives a negative determinant.
      point_queue.push_back(make_point(-20000, 30000, -one, -one, -one, one, one, one, one, -one));
      point_queue.push_back(make_point(65535, -65535, -3, 7, 9, -2, 5, 11, -8, 4));
      // Hold off until the block has drained before the random part.
      point_queue[$].wait_empty = 1'b1;

      for (int ph = 0; ph < 4; ph++) begin
         for (int n = 0; n < 50; n++) begin
            p = random_point(send_pct[ph], recv_pct[ph]);
            p.wait_empty = (n == 0);
            point_queue.push_back(p);
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (point_queue.size() == 0 && !(req_valid && !req_taken));
      @(posedge clock);
      points_done = 1'b1;
      wait (node_results_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d points, checked %0d node results (%0d flagged singular).",
               points_sent, results_seen, singular_seen);
      $display("Idle profiles: none, sender 76%%, receiver 76%%, both 30%%.");
      if (error_count == 0 && node_results_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
